// File: hw/rtl/tgm_pkg.sv
// Shared types, codes and constants for the touch gesture to mouse block.
package tgm_pkg;

  localparam int SMOOTH_DEPTH_DEF = 4;
  localparam int CMD_Q_DEPTH      = 4;
  localparam int RES_Q_DEPTH      = 4;

  localparam int DELTA_W = 12;
  localparam int POS_W   = 11;
  localparam int TIME_W  = 32;
  localparam int MOVE_W  = 13;
  localparam int DIST_W  = 12;
  localparam int MS_W    = 16;
  localparam int Q_W     = 12;

  // floor(b / 10) = (b * 6554) >> 16 for every b below 4096
  localparam int DIV10_W  = 13;
  localparam int DIV10_SH = 16;
  localparam logic [DIV10_W-1:0] DIV10_MUL = 13'd6554;
  localparam int TENTH_W  = Q_W + DIV10_W - DIV10_SH;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_MOVE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] BTN_MOVE = 2'd0;
  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_UP   = 2'd2;

  localparam logic [1:0] REG_DRAG_DISTANCE = 2'd0;
  localparam logic [1:0] REG_DRAG_HOLD_MS  = 2'd1;
  localparam logic [1:0] REG_CLICK_MAX_MS  = 2'd2;
  localparam logic [1:0] REG_FAST_GAP_MS   = 2'd3;

  localparam logic [DIST_W-1:0] DRAG_DISTANCE_RST = 12'd10;
  localparam logic [MS_W-1:0]   DRAG_HOLD_MS_RST  = 16'd50;
  localparam logic [MS_W-1:0]   CLICK_MAX_MS_RST  = 16'd300;
  localparam logic [MS_W-1:0]   FAST_GAP_MS_RST   = 16'd50;

  typedef struct packed {
    logic [DIST_W-1:0] drag_distance;
    logic [MS_W-1:0]   drag_hold_ms;
    logic [MS_W-1:0]   click_max_ms;
    logic [MS_W-1:0]   fast_gap_ms;
  } cfg_t;

endpackage

// File: hw/rtl/tgm_fifo.sv
// Small register-based queue with fill level.
module tgm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (level_r == LW'(DEPTH));
  assign empty   = (level_r == '0);
  assign level   = level_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/tgm_front.sv
// Gesture tracker: classifies touch events, keeps the delta ring and issues commands.
module tgm_front #(
  parameter int SMOOTH_DEPTH = tgm_pkg::SMOOTH_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tgm_pkg::cfg_t                          cfg,
  input  logic                                   in_accept,
  input  logic [1:0]                             in_op,
  input  logic [tgm_pkg::POS_W-1:0]              in_pos_x,
  input  logic [tgm_pkg::POS_W-1:0]              in_pos_y,
  input  logic signed [tgm_pkg::DELTA_W-1:0]     in_delta_x,
  input  logic signed [tgm_pkg::DELTA_W-1:0]     in_delta_y,
  input  logic [tgm_pkg::TIME_W-1:0]             in_now_ms,
  output logic                                   cmd_push,
  output logic [2*(tgm_pkg::DELTA_W + $clog2(SMOOTH_DEPTH))+1:0] cmd_data
);
  import tgm_pkg::*;

  localparam int SUM_W = DELTA_W + $clog2(SMOOTH_DEPTH);
  localparam int RP_W  = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam logic [RP_W-1:0] RP_LAST = RP_W'(SMOOTH_DEPTH - 1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ARMED = 2'd1;
  localparam logic [1:0] MODE_DRAG  = 2'd2;

  logic [1:0]                mode_r, mode_nxt;
  logic [TIME_W-1:0]         press_time_r, press_time_nxt;
  logic [TIME_W-1:0]         last_move_r, last_move_nxt;
  logic [POS_W-1:0]          press_x_r, press_x_nxt;
  logic [POS_W-1:0]          press_y_r, press_y_nxt;
  logic signed [DELTA_W-1:0] ring_x_r [SMOOTH_DEPTH];
  logic signed [DELTA_W-1:0] ring_x_nxt [SMOOTH_DEPTH];
  logic signed [DELTA_W-1:0] ring_y_r [SMOOTH_DEPTH];
  logic signed [DELTA_W-1:0] ring_y_nxt [SMOOTH_DEPTH];
  logic [RP_W-1:0]           ring_pos_r, ring_pos_nxt;
  logic signed [SUM_W-1:0]   sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0]   sum_y_r, sum_y_nxt;

  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] gap;
  logic [POS_W-1:0]  adx;
  logic [POS_W-1:0]  ady;
  logic [DIST_W-1:0] man_dist;
  logic              cmd_click;
  logic              cmd_fast;

  always_comb begin
    held = in_now_ms - press_time_r;
    gap  = in_now_ms - last_move_r;
    adx  = (in_pos_x >= press_x_r) ? in_pos_x - press_x_r : press_x_r - in_pos_x;
    ady  = (in_pos_y >= press_y_r) ? in_pos_y - press_y_r : press_y_r - in_pos_y;
    man_dist = DIST_W'(adx) + DIST_W'(ady);

    mode_nxt       = mode_r;
    press_time_nxt = press_time_r;
    last_move_nxt  = last_move_r;
    press_x_nxt    = press_x_r;
    press_y_nxt    = press_y_r;
    ring_x_nxt     = ring_x_r;
    ring_y_nxt     = ring_y_r;
    ring_pos_nxt   = ring_pos_r;
    sum_x_nxt      = sum_x_r;
    sum_y_nxt      = sum_y_r;
    cmd_push       = 1'b0;
    cmd_click      = 1'b0;
    cmd_fast       = 1'b0;

    if (in_accept) begin
      case (in_op)
        OP_PRESS: begin
          mode_nxt       = MODE_ARMED;
          press_time_nxt = in_now_ms;
          last_move_nxt  = in_now_ms;
          press_x_nxt    = in_pos_x;
          press_y_nxt    = in_pos_y;
          for (int i = 0; i < SMOOTH_DEPTH; i++) begin
            ring_x_nxt[i] = '0;
            ring_y_nxt[i] = '0;
          end
          ring_pos_nxt = '0;
          sum_x_nxt    = '0;
          sum_y_nxt    = '0;
        end
        OP_MOVE: begin
          last_move_nxt = in_now_ms;
          if ((mode_r == MODE_DRAG) ||
              (mode_r == MODE_ARMED && held >= TIME_W'(cfg.drag_hold_ms) &&
               man_dist >= cfg.drag_distance)) begin
            mode_nxt               = MODE_DRAG;
            ring_x_nxt[ring_pos_r] = in_delta_x;
            ring_y_nxt[ring_pos_r] = in_delta_y;
            sum_x_nxt = sum_x_r - SUM_W'(ring_x_r[ring_pos_r]) + SUM_W'(in_delta_x);
            sum_y_nxt = sum_y_r - SUM_W'(ring_y_r[ring_pos_r]) + SUM_W'(in_delta_y);
            ring_pos_nxt = (ring_pos_r == RP_LAST) ? '0 : ring_pos_r + 1'b1;
            cmd_push     = 1'b1;
            cmd_fast     = (gap < TIME_W'(cfg.fast_gap_ms));
          end
        end
        OP_RELEASE: begin
          cmd_click = (mode_r == MODE_ARMED) && (held <= TIME_W'(cfg.click_max_ms)) &&
                      (man_dist < cfg.drag_distance);
          cmd_push       = cmd_click;
          mode_nxt       = MODE_IDLE;
          press_time_nxt = '0;
          last_move_nxt  = '0;
          for (int i = 0; i < SMOOTH_DEPTH; i++) begin
            ring_x_nxt[i] = '0;
            ring_y_nxt[i] = '0;
          end
          ring_pos_nxt = '0;
          sum_x_nxt    = '0;
          sum_y_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_data = {cmd_click, cmd_fast, sum_x_nxt, sum_y_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      press_time_r <= '0;
      last_move_r  <= '0;
      press_x_r    <= '0;
      press_y_r    <= '0;
      for (int i = 0; i < SMOOTH_DEPTH; i++) begin
        ring_x_r[i] <= '0;
        ring_y_r[i] <= '0;
      end
      ring_pos_r <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
    end else begin
      mode_r       <= mode_nxt;
      press_time_r <= press_time_nxt;
      last_move_r  <= last_move_nxt;
      press_x_r    <= press_x_nxt;
      press_y_r    <= press_y_nxt;
      ring_x_r     <= ring_x_nxt;
      ring_y_r     <= ring_y_nxt;
      ring_pos_r   <= ring_pos_nxt;
      sum_x_r      <= sum_x_nxt;
      sum_y_r      <= sum_y_nxt;
    end
  end

endmodule

// File: hw/rtl/tgm_back.sv
// Report engine: averages and boosts deltas, queues reports and sequences click beats.
module tgm_back #(
  parameter int SMOOTH_DEPTH = tgm_pkg::SMOOTH_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cmd_empty,
  input  logic [2*(tgm_pkg::DELTA_W + $clog2(SMOOTH_DEPTH))+1:0] cmd_rdata,
  output logic                                   cmd_pop,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [tgm_pkg::MOVE_W-1:0]      out_move_x,
  output logic signed [tgm_pkg::MOVE_W-1:0]      out_move_y,
  output logic [1:0]                             out_button,
  output logic                                   out_last
);
  import tgm_pkg::*;

  localparam int SUM_W = DELTA_W + $clog2(SMOOTH_DEPTH);
  localparam int CMD_W = 2 * SUM_W + 2;
  localparam int K_W   = SUM_W + $clog2(SMOOTH_DEPTH);
  localparam int MUL_W = K_W + 1;
  localparam int P1_W  = SUM_W + MUL_W;
  localparam int RECIP = ((1 << K_W) + SMOOTH_DEPTH - 1) / SMOOTH_DEPTH;
  localparam logic [MUL_W-1:0] RECIP_V = MUL_W'(RECIP);
  localparam int P2_W  = Q_W + DIV10_W;
  localparam int RES_W = 2 * MOVE_W + 1;
  localparam int RL_W  = $clog2(RES_Q_DEPTH + 1);

  logic                    c_click;
  logic                    c_fast;
  logic signed [SUM_W-1:0] c_sx;
  logic signed [SUM_W-1:0] c_sy;
  logic [SUM_W-1:0]        c_mx;
  logic [SUM_W-1:0]        c_my;
  logic                    room;

  logic              v1_r, v1_nxt;
  logic              click1_r, fast1_r, sgnx1_r, sgny1_r;
  logic [P1_W-1:0]   p1x_r, p1x_nxt;
  logic [P1_W-1:0]   p1y_r, p1y_nxt;

  logic [Q_W-1:0]    q_x;
  logic [Q_W-1:0]    q_y;
  logic              v2_r, v2_nxt;
  logic              click2_r, fast2_r, sgnx2_r, sgny2_r;
  logic [Q_W-1:0]    q2x_r, q2y_r;
  logic [P2_W-1:0]   p2x_r, p2x_nxt;
  logic [P2_W-1:0]   p2y_r, p2y_nxt;

  logic [MOVE_W-1:0] r_x;
  logic [MOVE_W-1:0] r_y;
  logic [MOVE_W-1:0] m_x;
  logic [MOVE_W-1:0] m_y;
  logic [RES_W-1:0]  res_wdata;
  logic [RES_W-1:0]  res_rdata;
  logic [RL_W-1:0]   res_level;
  logic              res_pop;
  logic              head_click;
  logic              phase_r, phase_nxt;

  assign c_click = cmd_rdata[CMD_W-1];
  assign c_fast  = cmd_rdata[CMD_W-2];
  assign c_sx    = signed'(cmd_rdata[2*SUM_W-1:SUM_W]);
  assign c_sy    = signed'(cmd_rdata[SUM_W-1:0]);
  assign c_mx    = c_sx[SUM_W-1] ? SUM_W'(-c_sx) : SUM_W'(c_sx);
  assign c_my    = c_sy[SUM_W-1] ? SUM_W'(-c_sy) : SUM_W'(c_sy);

  // reserve result queue space for every report still in the pipeline
  assign room    = ((RL_W+1)'(res_level) + (RL_W+1)'(v1_r) + (RL_W+1)'(v2_r)) <
                   (RL_W+1)'(RES_Q_DEPTH);
  assign cmd_pop = !cmd_empty && room;

  always_comb begin
    v1_nxt  = cmd_pop;
    p1x_nxt = {{MUL_W{1'b0}}, c_mx} * {{SUM_W{1'b0}}, RECIP_V};
    p1y_nxt = {{MUL_W{1'b0}}, c_my} * {{SUM_W{1'b0}}, RECIP_V};
  end

  always_comb begin
    q_x     = p1x_r[K_W +: Q_W];
    q_y     = p1y_r[K_W +: Q_W];
    v2_nxt  = v1_r && (click1_r || q_x != '0 || q_y != '0);
    p2x_nxt = {{DIV10_W{1'b0}}, q_x} * {{Q_W{1'b0}}, DIV10_MUL};
    p2y_nxt = {{DIV10_W{1'b0}}, q_y} * {{Q_W{1'b0}}, DIV10_MUL};
  end

  always_comb begin
    r_x = MOVE_W'(q2x_r);
    r_y = MOVE_W'(q2y_r);
    if (fast2_r) begin
      r_x = MOVE_W'(q2x_r) + MOVE_W'(p2x_r[DIV10_SH +: TENTH_W]);
      r_y = MOVE_W'(q2y_r) + MOVE_W'(p2y_r[DIV10_SH +: TENTH_W]);
    end
    m_x = sgnx2_r ? -r_x : r_x;
    m_y = sgny2_r ? -r_y : r_y;
    if (click2_r) begin
      m_x = '0;
      m_y = '0;
    end
    res_wdata = {click2_r, m_x, m_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    click1_r <= c_click;
    fast1_r  <= c_fast;
    sgnx1_r  <= c_sx[SUM_W-1];
    sgny1_r  <= c_sy[SUM_W-1];
    p1x_r    <= p1x_nxt;
    p1y_r    <= p1y_nxt;
    click2_r <= click1_r;
    fast2_r  <= fast1_r;
    sgnx2_r  <= sgnx1_r;
    sgny2_r  <= sgny1_r;
    q2x_r    <= q_x;
    q2y_r    <= q_y;
    p2x_r    <= p2x_nxt;
    p2y_r    <= p2y_nxt;
  end

  tgm_fifo #(
    .W     (RES_W),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (v2_r),
    .wdata (res_wdata),
    .full  (),
    .pop   (res_pop),
    .rdata (res_rdata),
    .empty (empty),
    .level (res_level)
  );

  // a click entry leaves as two beats: button down, then button up
  assign head_click = res_rdata[RES_W-1];
  assign res_pop    = pop && !empty && (!head_click || phase_r);
  assign out_move_x = signed'(res_rdata[2*MOVE_W-1:MOVE_W]);
  assign out_move_y = signed'(res_rdata[MOVE_W-1:0]);
  assign out_button = head_click ? (phase_r ? BTN_UP : BTN_DOWN) : BTN_MOVE;
  assign out_last   = !head_click || phase_r;

  always_comb begin
    phase_nxt = phase_r;
    if (pop && !empty && head_click) begin
      phase_nxt = !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: hw/rtl/touch_gesture_to_mouse.sv
// Top level: configuration registers, gesture tracker, command queue and report engine.
//
//   channel   direction  handshake            beat
//   input     in         push / full          op, pos, delta, timestamp of one touch event
//   result    out        empty / pop          one mouse report (move, button down, button up)
//   config    cfg        psel/penable/pready  one 32-bit register write or read
//
// Touch events are taken one per cycle while the command queue has room; the gesture
// tracker updates its state in the accept cycle. The report engine has a two-stage
// multiply pipeline ahead of the result queue; a click's two beats come from one
// queue entry and its press gives none; events enter while older ones are in flight.
// Reset is synchronous; it empties both queues and restores register defaults.
// A stalled result side fills the result queue, then the command queue, then raises full.
module touch_gesture_to_mouse #(
  parameter int SMOOTH_DEPTH = tgm_pkg::SMOOTH_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         in_op,
  input  logic [tgm_pkg::POS_W-1:0]          in_pos_x,
  input  logic [tgm_pkg::POS_W-1:0]          in_pos_y,
  input  logic signed [tgm_pkg::DELTA_W-1:0] in_delta_x,
  input  logic signed [tgm_pkg::DELTA_W-1:0] in_delta_y,
  input  logic [tgm_pkg::TIME_W-1:0]         in_now_ms,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [tgm_pkg::MOVE_W-1:0]  out_move_x,
  output logic signed [tgm_pkg::MOVE_W-1:0]  out_move_y,
  output logic [1:0]                         out_button,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tgm_pkg::*;

  localparam int SUM_W = DELTA_W + $clog2(SMOOTH_DEPTH);
  localparam int CMD_W = 2 * SUM_W + 2;

  cfg_t             cfg_r, cfg_nxt;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic             in_accept;
  logic             cmd_push;
  logic [CMD_W-1:0] cmd_wdata;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_rdata;
  logic             cmd_empty;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_DRAG_DISTANCE: cfg_nxt.drag_distance = pwdata[DIST_W-1:0];
        REG_DRAG_HOLD_MS:  cfg_nxt.drag_hold_ms  = pwdata[MS_W-1:0];
        REG_CLICK_MAX_MS:  cfg_nxt.click_max_ms  = pwdata[MS_W-1:0];
        REG_FAST_GAP_MS:   cfg_nxt.fast_gap_ms   = pwdata[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DRAG_DISTANCE: prdata = 32'(cfg_r.drag_distance);
      REG_DRAG_HOLD_MS:  prdata = 32'(cfg_r.drag_hold_ms);
      REG_CLICK_MAX_MS:  prdata = 32'(cfg_r.click_max_ms);
      REG_FAST_GAP_MS:   prdata = 32'(cfg_r.fast_gap_ms);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drag_distance <= DRAG_DISTANCE_RST;
      cfg_r.drag_hold_ms  <= DRAG_HOLD_MS_RST;
      cfg_r.click_max_ms  <= CLICK_MAX_MS_RST;
      cfg_r.fast_gap_ms   <= FAST_GAP_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_accept = push && !full;

  tgm_front #(
    .SMOOTH_DEPTH (SMOOTH_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_accept  (in_accept),
    .in_op      (in_op),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_delta_x (in_delta_x),
    .in_delta_y (in_delta_y),
    .in_now_ms  (in_now_ms),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_wdata)
  );

  tgm_fifo #(
    .W     (CMD_W),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty),
    .level ()
  );

  tgm_back #(
    .SMOOTH_DEPTH (SMOOTH_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd_rdata  (cmd_rdata),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_move_x (out_move_x),
    .out_move_y (out_move_y),
    .out_button (out_button),
    .out_last   (out_last)
  );

endmodule

// File: hw/rtl/tgm_checker.sv
// Port-level checks on the mouse report stream, bound to the top level.
module tgm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              empty,
  input logic                              pop,
  input logic signed [tgm_pkg::MOVE_W-1:0] out_move_x,
  input logic signed [tgm_pkg::MOVE_W-1:0] out_move_y,
  input logic [1:0]                        out_button,
  input logic                              out_last
);
  import tgm_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_down_then_up: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_button == BTN_DOWN) |=>
      (!empty && out_button == BTN_UP && out_last))
    else $error("button down beat not followed by button up");

  a_down_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_button == BTN_DOWN) |->
      (!out_last && out_move_x == '0 && out_move_y == '0))
    else $error("malformed button down beat");

  a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_button == BTN_MOVE) |->
      (out_last && (out_move_x != '0 || out_move_y != '0)))
    else $error("move report with no motion");

endmodule

bind touch_gesture_to_mouse tgm_checker u_tgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .empty      (empty),
  .pop        (pop),
  .out_move_x (out_move_x),
  .out_move_y (out_move_y),
  .out_button (out_button),
  .out_last   (out_last)
);
